// ----- rtl/ntts_pkg.sv -----
package ntts_pkg;

  localparam int unsigned FreqW    = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned TempoW   = 9;
  localparam int unsigned ToneDivW = FreqW;
  localparam int unsigned NoteDivW = TempoW + FracW;
  localparam int unsigned QuotW    = 23;
  localparam int unsigned NumSteps = QuotW;

  localparam logic [TempoW-1:0] TempoReset = 9'd120;
  localparam logic [FreqW-1:0]  MinFreq    = 16'd8;
  localparam logic [QuotW-1:0]  ToneNum    = 23'd500000;
  localparam logic [QuotW-1:0]  NoteNum    = 23'd7500000;

  typedef struct packed {
    logic [FreqW-1:0] tone_freq;
    logic [FracW-1:0] note_fraction;
  } in_t;

  typedef struct packed {
    logic [15:0] pwm_top;
    logic [14:0] pwm_compare;
    logic [14:0] overflow_count;
    logic [7:0]  remainder_ticks;
    logic        bad_note;
  } out_t;

  // Partial state of both dividers; dq shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic                bad;
    logic [ToneDivW-1:0] tone_div;
    logic [ToneDivW-1:0] tone_rem;
    logic [QuotW-1:0]    tone_dq;
    logic [NoteDivW-1:0] note_div;
    logic [NoteDivW-1:0] note_rem;
    logic [QuotW-1:0]    note_dq;
  } cell_t;

endpackage

// ----- rtl/ntts_head.sv -----
module ntts_head (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tempo_we_i,
  input  logic [ntts_pkg::TempoW-1:0]   tempo_bpm_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ntts_pkg::in_t                 in_data_i,
  output logic                          vld_o,
  output ntts_pkg::cell_t               data_o,
  input  logic                          rdy_i
);

  logic [ntts_pkg::TempoW-1:0]   tempo_q;
  logic                          vld_q;
  ntts_pkg::cell_t               data_q, data_d;
  logic [ntts_pkg::NoteDivW-1:0] prod;
  logic                          rdy;

  assign rdy        = !vld_q || rdy_i;
  assign in_stall_o = !rdy;
  assign prod       = {{ntts_pkg::FracW{1'b0}}, tempo_q} *
                      {{ntts_pkg::TempoW{1'b0}}, in_data_i.note_fraction};

  always_comb begin
    data_d          = '0;
    data_d.bad      = (in_data_i.tone_freq < ntts_pkg::MinFreq) || (prod == '0);
    data_d.tone_div = in_data_i.tone_freq;
    data_d.tone_dq  = ntts_pkg::ToneNum;
    data_d.note_div = prod;
    data_d.note_dq  = ntts_pkg::NoteNum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= ntts_pkg::TempoReset;
      vld_q   <= 1'b0;
    end else begin
      if (tempo_we_i) begin
        tempo_q <= tempo_bpm_i;
      end
      if (rdy) begin
        vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/ntts_cell.sv -----
module ntts_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  ntts_pkg::cell_t data_i,
  output logic            rdy_o,
  output logic            vld_o,
  output ntts_pkg::cell_t data_o,
  input  logic            rdy_i
);

  logic                          vld_q;
  ntts_pkg::cell_t               data_q, data_d;
  logic [ntts_pkg::ToneDivW:0]   tone_trial;
  logic [ntts_pkg::NoteDivW:0]   note_trial;
  logic                          tone_bit, note_bit;

  assign rdy_o = !vld_q || rdy_i;

  // One restoring step per lane: pull in the next dividend bit, subtract if it fits.
  always_comb begin
    tone_trial = {data_i.tone_rem, data_i.tone_dq[ntts_pkg::QuotW-1]};
    note_trial = {data_i.note_rem, data_i.note_dq[ntts_pkg::QuotW-1]};
    tone_bit   = tone_trial >= {1'b0, data_i.tone_div};
    note_bit   = note_trial >= {1'b0, data_i.note_div};
    data_d     = data_i;
    if (tone_bit) begin
      tone_trial = tone_trial - {1'b0, data_i.tone_div};
    end
    if (note_bit) begin
      note_trial = note_trial - {1'b0, data_i.note_div};
    end
    data_d.tone_rem = tone_trial[ntts_pkg::ToneDivW-1:0];
    data_d.note_rem = note_trial[ntts_pkg::NoteDivW-1:0];
    data_d.tone_dq  = {data_i.tone_dq[ntts_pkg::QuotW-2:0], tone_bit};
    data_d.note_dq  = {data_i.note_dq[ntts_pkg::QuotW-2:0], note_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/ntts_out.sv -----
module ntts_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  ntts_pkg::cell_t data_i,
  output logic            rdy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ntts_pkg::out_t  out_data_o
);

  logic           vld_q;
  ntts_pkg::out_t data_q, data_d;

  assign rdy_o = !vld_q || !out_stall_i;

  // Zero every timer field on a bad note.
  always_comb begin
    data_d = '0;
    data_d.bad_note = data_i.bad;
    if (!data_i.bad) begin
      data_d.pwm_top         = data_i.tone_dq[15:0];
      data_d.pwm_compare     = data_i.tone_dq[15:1];
      data_d.overflow_count  = data_i.note_dq[22:8];
      data_d.remainder_ticks = data_i.note_dq[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/note_to_timer_settings.sv -----
// Channel   Direction  Handshake                   Payload
// note in   input      in_valid_i / in_stall_o     in_data_i  (ntts_pkg::in_t)
// result    output     out_valid_o / out_stall_i   out_data_o (ntts_pkg::out_t)
// tempo     input      tempo_we_i                  tempo_bpm_i
//
// One note per cycle enters while in_stall_o is low; its result passes an input stage
// that forms tempo * fraction, 23 divider cells (one quotient bit each for both
// dividers), and an output register. Each stage holds while the next is full and
// stalled, so bubbles close up. Reset clears all valid flags and sets the tempo to 120.
module note_to_timer_settings (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tempo_we_i,
  input  logic [ntts_pkg::TempoW-1:0] tempo_bpm_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ntts_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ntts_pkg::out_t              out_data_o
);

  logic            vld [ntts_pkg::NumSteps+1];
  logic            rdy [ntts_pkg::NumSteps+1];
  ntts_pkg::cell_t data[ntts_pkg::NumSteps+1];

  ntts_head u_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tempo_we_i  (tempo_we_i),
    .tempo_bpm_i (tempo_bpm_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .vld_o       (vld[0]),
    .data_o      (data[0]),
    .rdy_i       (rdy[0])
  );

  for (genvar k = 0; k < ntts_pkg::NumSteps; k++) begin : g_cell
    ntts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .data_i (data[k]),
      .rdy_o  (rdy[k]),
      .vld_o  (vld[k+1]),
      .data_o (data[k+1]),
      .rdy_i  (rdy[k+1])
    );
  end

  ntts_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (vld[ntts_pkg::NumSteps]),
    .data_i      (data[ntts_pkg::NumSteps]),
    .rdy_o       (rdy[ntts_pkg::NumSteps]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/note_to_timer_settings_test.sv -----
module note_to_timer_settings_test;

  localparam int unsigned ToneCycles   = 500000;
  localparam int unsigned NoteTicksNum = 7500000;
  localparam int unsigned LowestFreq   = 8;
  localparam int unsigned TicksPerOvf  = 256;
  localparam int unsigned DrainCycles  = 30;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned NotesPerRun  = 250;

  typedef struct packed {
    logic [ntts_pkg::TempoW-1:0] bpm;
    ntts_pkg::in_t               note;
    logic                        fixed;
    ntts_pkg::out_t              want;
  } note_row_t;

  localparam ntts_pkg::out_t BadNote = '{16'd0, 15'd0, 15'd0, 8'd0, 1'b1};
  localparam ntts_pkg::out_t Derived = '{16'd0, 15'd0, 15'd0, 8'd0, 1'b0};

  localparam note_row_t NoteRows [20] = '{
    '{9'd120, '{16'd0, 8'd4},          1'b1, BadNote},
    '{9'd120, '{16'd7, 8'd4},          1'b1, BadNote},
    '{9'd120, '{16'd8, 8'd1},          1'b1, '{16'd62500, 15'd31250, 15'd244, 8'd36, 1'b0}},
    '{9'd120, '{16'd9, 8'd4},          1'b0, Derived},
    '{9'd120, '{16'd65535, 8'd255},    1'b1, '{16'd7, 15'd3, 15'd0, 8'd245, 1'b0}},
    '{9'd120, '{16'd440, 8'd0},        1'b1, BadNote},
    '{9'd120, '{16'd65535, 8'd0},      1'b1, BadNote},
    '{9'd120, '{16'd0, 8'd0},          1'b1, BadNote},
    '{9'd120, '{16'd65535, 8'd1},      1'b1, '{16'd7, 15'd3, 15'd244, 8'd36, 1'b0}},
    '{9'd120, '{16'd440, 8'd4},        1'b0, Derived},
    '{9'd120, '{16'd1000, 8'd16},      1'b0, Derived},
    '{9'd120, '{16'h5555, 8'hAA},      1'b0, Derived},
    '{9'd120, '{16'hAAAA, 8'h55},      1'b0, Derived},
    '{9'd120, '{16'h8000, 8'h80},      1'b0, Derived},
    '{9'd120, '{16'd262, 8'd2},        1'b0, Derived},
    '{9'd1,   '{16'd8, 8'd1},          1'b1, '{16'd62500, 15'd31250, 15'd29296, 8'd224, 1'b0}},
    '{9'd1,   '{16'd65535, 8'd255},    1'b0, Derived},
    '{9'd0,   '{16'd440, 8'd4},        1'b1, BadNote},
    '{9'd511, '{16'd8, 8'd255},        1'b1, '{16'd62500, 15'd31250, 15'd0, 8'd57, 1'b0}},
    '{9'd300, '{16'd1000, 8'd1},       1'b1, '{16'd500, 15'd250, 15'd97, 8'd168, 1'b0}}
  };

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        tempo_we_i  = 1'b0;
  logic [ntts_pkg::TempoW-1:0] tempo_bpm_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  ntts_pkg::in_t               in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  ntts_pkg::out_t              out_data_o;

  logic [ntts_pkg::TempoW-1:0] tempo_now = ntts_pkg::TempoReset;
  ntts_pkg::out_t              pending_settings [$];
  int unsigned                 fault_count     = 0;
  int unsigned                 quiet_cycles    = 0;
  int unsigned                 send_idle_pct   = 0;
  int unsigned                 recv_stall_pct  = 0;

  note_to_timer_settings i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tempo_we_i  (tempo_we_i),
    .tempo_bpm_i (tempo_bpm_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic ntts_pkg::out_t timer_settings(ntts_pkg::in_t note,
                                                    logic [ntts_pkg::TempoW-1:0] bpm);
    ntts_pkg::out_t res;
    int unsigned    freq;
    int unsigned    frac;
    int unsigned    span;
    int unsigned    top;
    int unsigned    ticks;
    res  = '0;
    freq = 32'(note.tone_freq);
    frac = 32'(note.note_fraction);
    span = 32'(bpm);
    if (freq < LowestFreq || frac == 0 || span == 0) begin
      res.bad_note = 1'b1;
    end else begin
      span  = span * frac;
      ticks = NoteTicksNum / span;
      top   = ToneCycles / freq;
      res.pwm_top         = top[15:0];
      res.pwm_compare     = 15'(top / 2);
      res.overflow_count  = 15'(ticks / TicksPerOvf);
      res.remainder_ticks = 8'(ticks % TicksPerOvf);
    end
    return res;
  endfunction

  function automatic ntts_pkg::in_t random_note();
    ntts_pkg::in_t note;
    case ($urandom_range(0, 9))
      0:       note.tone_freq = 16'($urandom_range(0, 15));
      1:       note.tone_freq = 16'hFFFF;
      default: note.tone_freq = 16'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0:       note.note_fraction = '0;
      1:       note.note_fraction = 8'hFF;
      2:       note.note_fraction = 8'($urandom_range(1, 16));
      default: note.note_fraction = 8'($urandom_range(1, 255));
    endcase
    return note;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Hold the transaction until accepted; queue its expected settings.
  task automatic send_note(ntts_pkg::in_t note, logic fixed, ntts_pkg::out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= note;
    do @(posedge clk_i); while (in_stall_o);
    pending_settings.push_back(fixed ? want : timer_settings(note, tempo_now));
  endtask

  // Drain the pipe before touching the tempo.
  task automatic set_tempo(logic [ntts_pkg::TempoW-1:0] bpm);
    in_valid_i <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    tempo_we_i  <= 1'b1;
    tempo_bpm_i <= bpm;
    @(posedge clk_i);
    tempo_we_i <= 1'b0;
    tempo_now  = bpm;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_settings.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, out_data_o);
          fault_count++;
        end else begin
          ntts_pkg::out_t want;
          want = pending_settings.pop_front();
          report_field("pwm_top", 32'(want.pwm_top), 32'(out_data_o.pwm_top));
          report_field("pwm_compare", 32'(want.pwm_compare),
                       32'(out_data_o.pwm_compare));
          report_field("overflow_count", 32'(want.overflow_count),
                       32'(out_data_o.overflow_count));
          report_field("remainder_ticks", 32'(want.remainder_ticks),
                       32'(out_data_o.remainder_ticks));
          report_field("bad_note", 32'(want.bad_note), 32'(out_data_o.bad_note));
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [ntts_pkg::TempoW-1:0] bpm;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (NoteRows[r]) begin
      if (NoteRows[r].bpm != tempo_now) set_tempo(NoteRows[r].bpm);
      send_note(NoteRows[r].note, NoteRows[r].fixed, NoteRows[r].want);
    end

    for (int run = 0; run < 8; run++) begin
      case (run)
        0:       bpm = 9'd1;
        1:       bpm = 9'd300;
        2:       bpm = 9'd511;
        3:       bpm = 9'd0;
        4:       bpm = 9'($urandom_range(1, 300));
        5:       bpm = 9'($urandom_range(301, 511));
        6:       bpm = 9'($urandom_range(2, 299));
        default: bpm = ntts_pkg::TempoReset;
      endcase
      set_tempo(bpm);
      case (run % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      repeat (NotesPerRun) send_note(random_note(), 1'b0, Derived);
    end

    in_valid_i <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- note_to_timer_settings.f -----
rtl/ntts_pkg.sv
rtl/ntts_head.sv
rtl/ntts_cell.sv
rtl/ntts_out.sv
rtl/note_to_timer_settings.sv
dv/note_to_timer_settings_test.sv
